@@ rtl/core/tdnm_pkg.sv @@
// tdnm_pkg: shared types, constants and the priority search function
// for the time-of-day next-match pipeline. No dependencies.
`default_nettype none

package tdnm_pkg;

   // field widths
   localparam int HOUR_W = 5;
   localparam int UNIT_W = 6;
   localparam int MSEC_W = 10;
   localparam int WAIT_W = 27;
   localparam int SECS_W = 17;
   localparam int DAYS_W = 18;
   localparam int CSR_W  = 60;
   localparam int IDX_W  = 2;

   // time constants
   localparam logic [HOUR_W-1:0] HOUR_MAX      = 5'd23;
   localparam logic [UNIT_W-1:0] UNIT_MAX      = 6'd59;
   localparam logic [MSEC_W-1:0] MSEC_MAX      = 10'd999;
   localparam logic [DAYS_W-1:0] SEC_PER_HOUR  = 18'd3600;
   localparam logic [DAYS_W-1:0] SEC_PER_MIN   = 18'd60;
   localparam logic [DAYS_W-1:0] SEC_PER_DAY   = 18'd86400;
   localparam logic [WAIT_W-1:0] MS_PER_SEC    = 27'd1000;
   localparam logic [WAIT_W-1:0] MAX_WAIT_INIT = 27'd86400000;

   // register indexes
   localparam logic [IDX_W-1:0] REG_HOUR_SET   = 2'd0;
   localparam logic [IDX_W-1:0] REG_MINUTE_SET = 2'd1;
   localparam logic [IDX_W-1:0] REG_SECOND_SET = 2'd2;
   localparam logic [IDX_W-1:0] REG_MAX_WAIT   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_LONG  = 2'd2;

   typedef struct packed {
      logic [23:0] hour_set;
      logic [59:0] minute_set;
      logic [59:0] second_set;
   } sets_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [UNIT_W-1:0] minute;
      logic [UNIT_W-1:0] second;
   } hms_type;

   typedef struct packed {
      hms_type           now;
      hms_type           next;
      logic              wrap;
      logic              empty;
      logic [MSEC_W-1:0] msec;
   } match_type;

   typedef struct packed {
      logic [SECS_W-1:0] diff;
      hms_type           next;
      logic              empty;
      logic [MSEC_W-1:0] msec;
   } diff_type;

   typedef struct packed {
      logic [WAIT_W-1:0] wait_ms;
      hms_type           next;
      logic              empty;
   } wait_type;

   typedef struct packed {
      logic              found;
      logic [UNIT_W-1:0] idx;
   } find_type;

   // lowest set bit of a 60-bit vector
   function automatic find_type lowest_set(input logic [59:0] vec);
      find_type r;
      r.found = |vec;
      r.idx   = '0;
      for (int i = 59; i >= 0; i--) begin
         if (vec[i]) begin
            r.idx = UNIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tdnm_search.sv @@
// tdnm_search: first pipeline stage, clamps the time of day and searches
// the hour, minute and second sets for the next match. Uses tdnm_pkg.
`default_nettype none

module tdnm_search
   import tdnm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sets_type          sets,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [HOUR_W-1:0] in_hour,
   input  wire logic [UNIT_W-1:0] in_minute,
   input  wire logic [UNIT_W-1:0] in_second,
   input  wire logic [MSEC_W-1:0] in_msec,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output match_type              out_data
);

   logic              valid_ff;
   match_type         data_ff;
   match_type         data_in;
   logic [HOUR_W-1:0] h_c;
   logic [UNIT_W-1:0] m_c;
   logic [UNIT_W-1:0] s_c;
   logic [MSEC_W-1:0] ms_c;
   logic [5:0]        h_shift;
   logic [6:0]        m_shift;
   logic [6:0]        s_shift;
   logic [23:0]       hours_after;
   find_type          f_hour;
   find_type          f_minute;
   find_type          f_second;
   find_type          a_hour;
   find_type          a_minute;
   find_type          a_second;
   logic              hour_hit;
   logic              minute_hit;

   // clamp out-of-range fields
   always_comb begin
      h_c  = (in_hour   > HOUR_MAX) ? HOUR_MAX : in_hour;
      m_c  = (in_minute > UNIT_MAX) ? UNIT_MAX : in_minute;
      s_c  = (in_second > UNIT_MAX) ? UNIT_MAX : in_second;
      ms_c = (in_msec   > MSEC_MAX) ? MSEC_MAX : in_msec;
   end

   // bits strictly above the current position
   assign h_shift     = 6'(h_c) + 6'd1;
   assign m_shift     = 7'(m_c) + 7'd1;
   assign s_shift     = 7'(s_c) + 7'd1;
   assign hours_after = sets.hour_set & ({24{1'b1}} << h_shift);

   assign f_hour   = lowest_set({36'd0, sets.hour_set});
   assign f_minute = lowest_set(sets.minute_set);
   assign f_second = lowest_set(sets.second_set);
   assign a_hour   = lowest_set({36'd0, hours_after});
   assign a_minute = lowest_set(sets.minute_set & ({60{1'b1}} << m_shift));
   assign a_second = lowest_set(sets.second_set & ({60{1'b1}} << s_shift));

   assign hour_hit   = sets.hour_set[h_c];
   assign minute_hit = sets.minute_set[m_c];

   // pick the next run time, carrying into minute, hour and next day
   always_comb begin
      data_in.now.hour   = h_c;
      data_in.now.minute = m_c;
      data_in.now.second = s_c;
      data_in.msec       = ms_c;
      data_in.empty      = !(f_hour.found && f_minute.found && f_second.found);
      data_in.wrap       = 1'b0;
      if (hour_hit && minute_hit && a_second.found) begin
         data_in.next.hour   = h_c;
         data_in.next.minute = m_c;
         data_in.next.second = a_second.idx;
      end else if (hour_hit && a_minute.found) begin
         data_in.next.hour   = h_c;
         data_in.next.minute = a_minute.idx;
         data_in.next.second = f_second.idx;
      end else if (a_hour.found) begin
         data_in.next.hour   = a_hour.idx[HOUR_W-1:0];
         data_in.next.minute = f_minute.idx;
         data_in.next.second = f_second.idx;
      end else begin
         data_in.next.hour   = f_hour.idx[HOUR_W-1:0];
         data_in.next.minute = f_minute.idx;
         data_in.next.second = f_second.idx;
         data_in.wrap        = 1'b1;
      end
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/core/tdnm_secs.sv @@
// tdnm_secs: second pipeline stage, turns both times into seconds of the
// day and forms their difference. Uses tdnm_pkg.
`default_nettype none

module tdnm_secs
   import tdnm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire match_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output diff_type       out_data
);

   logic              valid_ff;
   diff_type          data_ff;
   diff_type          data_in;
   logic [DAYS_W-1:0] now_sec;
   logic [DAYS_W-1:0] next_sec;
   logic [DAYS_W-1:0] day_add;

   // seconds of the day, next day adds a full day
   assign now_sec  = DAYS_W'(in_data.now.hour) * SEC_PER_HOUR
                   + DAYS_W'(in_data.now.minute) * SEC_PER_MIN
                   + DAYS_W'(in_data.now.second);
   assign day_add  = in_data.wrap ? SEC_PER_DAY : '0;
   assign next_sec = DAYS_W'(in_data.next.hour) * SEC_PER_HOUR
                   + DAYS_W'(in_data.next.minute) * SEC_PER_MIN
                   + DAYS_W'(in_data.next.second) + day_add;

   always_comb begin
      data_in.diff  = SECS_W'(next_sec - now_sec);
      data_in.next  = in_data.next;
      data_in.empty = in_data.empty;
      data_in.msec  = in_data.msec;
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/core/tdnm_scale.sv @@
// tdnm_scale: third pipeline stage, scales the seconds difference to
// milliseconds and takes off the current milliseconds. Uses tdnm_pkg.
`default_nettype none

module tdnm_scale
   import tdnm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire diff_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output wait_type      out_data
);

   logic              valid_ff;
   wait_type          data_ff;
   wait_type          data_in;
   logic [WAIT_W-1:0] product;

   // constant multiply by 1000, then subtract the milliseconds
   assign product = WAIT_W'(in_data.diff) * MS_PER_SEC;

   always_comb begin
      data_in.wait_ms = product - WAIT_W'(in_data.msec);
      data_in.next    = in_data.next;
      data_in.empty   = in_data.empty;
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/core/time_of_day_next_match.sv @@
// time_of_day_next_match: top level, configuration registers, three search
// and arithmetic stages and the result register. Uses tdnm_pkg, tdnm_search,
// tdnm_secs and tdnm_scale.
//
//   channel   direction  handshake             contents
//   req_      in         req_valid/req_ready   current time of day with ms
//   rsp_      out        rsp_valid/rsp_ready   wait, next run time, status
//   csr_      in         csr_write             register index and data
//
// Four register stages: set search, seconds difference, millisecond scaling,
// status and result register. One transaction can be accepted in every cycle
// while rsp_ready is high. Each stage holds its own valid bit and moves when
// the stage after it is empty or draining, so a stalled result backs up the
// pipe without losing or repeating a transaction. Reset empties the pipe,
// clears the three sets and loads the maximum wait with one full day.
`default_nettype none

module time_of_day_next_match
   import tdnm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [HOUR_W-1:0] req_current_hour,
   input  wire logic [UNIT_W-1:0] req_current_minute,
   input  wire logic [UNIT_W-1:0] req_current_second,
   input  wire logic [MSEC_W-1:0] req_current_millisecond,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WAIT_W-1:0]      rsp_wait_ms,
   output logic [HOUR_W-1:0]      rsp_next_hour,
   output logic [UNIT_W-1:0]      rsp_next_minute,
   output logic [UNIT_W-1:0]      rsp_next_second,
   output logic [1:0]             rsp_status,
   input  wire logic              csr_write,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   sets_type          sets_ff;
   logic [WAIT_W-1:0] max_wait_ff;
   logic              s1_valid;
   logic              s1_ready;
   match_type         s1_data;
   logic              s2_valid;
   logic              s2_ready;
   diff_type          s2_data;
   logic              s3_valid;
   logic              s3_ready;
   wait_type          s3_data;
   logic              rsp_valid_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic [WAIT_W-1:0] wait_in;
   hms_type           next_ff;
   hms_type           next_in;
   logic [1:0]        status_ff;
   logic [1:0]        status_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sets_ff     <= '0;
         max_wait_ff <= MAX_WAIT_INIT;
      end else if (csr_write) begin
         case (csr_index)
            REG_HOUR_SET:   sets_ff.hour_set   <= csr_wdata[23:0];
            REG_MINUTE_SET: sets_ff.minute_set <= csr_wdata;
            REG_SECOND_SET: sets_ff.second_set <= csr_wdata;
            REG_MAX_WAIT:   max_wait_ff        <= csr_wdata[WAIT_W-1:0];
            default:        sets_ff            <= sets_ff;
         endcase
      end
   end

   tdnm_search u_search (
      .clock     (clock),
      .reset     (reset),
      .sets      (sets_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_hour   (req_current_hour),
      .in_minute (req_current_minute),
      .in_second (req_current_second),
      .in_msec   (req_current_millisecond),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   tdnm_secs u_secs (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   tdnm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   // status and zeroing of fields
   always_comb begin
      if (s3_data.empty) begin
         status_in = STAT_EMPTY;
         wait_in   = '0;
         next_in   = '0;
      end else if (s3_data.wait_ms >= max_wait_ff) begin
         status_in = STAT_LONG;
         wait_in   = '0;
         next_in   = s3_data.next;
      end else begin
         status_in = STAT_OK;
         wait_in   = s3_data.wait_ms;
         next_in   = s3_data.next;
      end
   end

   // result register
   assign s3_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s3_valid) begin
         wait_ff   <= wait_in;
         next_ff   <= next_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wait_ms     = wait_ff;
   assign rsp_next_hour   = next_ff.hour;
   assign rsp_next_minute = next_ff.minute;
   assign rsp_next_second = next_ff.second;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

@@ rtl/core/tdnm_checker.sv @@
// tdnm_checker: port-level assertions for time_of_day_next_match and the
// bind that attaches them. Uses tdnm_pkg.
`default_nettype none

module tdnm_checker
   import tdnm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [WAIT_W-1:0] rsp_wait_ms,
   input wire logic [HOUR_W-1:0] rsp_next_hour,
   input wire logic [UNIT_W-1:0] rsp_next_minute,
   input wire logic [UNIT_W-1:0] rsp_next_second,
   input wire logic [1:0]        rsp_status
);

   // an empty set zeroes every field
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |->
         rsp_wait_ms == '0 && rsp_next_hour == '0 &&
         rsp_next_minute == '0 && rsp_next_second == '0)
      else $error("empty-set transaction with nonzero fields");

   // an out-of-range wait reads as zero
   a_long_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_LONG |-> rsp_wait_ms == '0)
      else $error("out-of-range transaction with nonzero wait");

   // a good result has a wait within one day and a legal time
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_OK |->
         rsp_wait_ms != '0 && rsp_wait_ms <= MAX_WAIT_INIT &&
         rsp_next_hour <= HOUR_MAX && rsp_next_minute <= UNIT_MAX &&
         rsp_next_second <= UNIT_MAX)
      else $error("ok transaction out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_wait_ms) && $stable(rsp_status) &&
         $stable(rsp_next_hour) && $stable(rsp_next_minute) &&
         $stable(rsp_next_second))
      else $error("stalled result transaction changed");

endmodule

bind time_of_day_next_match tdnm_checker u_tdnm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_wait_ms     (rsp_wait_ms),
   .rsp_next_hour   (rsp_next_hour),
   .rsp_next_minute (rsp_next_minute),
   .rsp_next_second (rsp_next_second),
   .rsp_status      (rsp_status)
);

`default_nettype wire

@@ sim/time_of_day_next_match_tb.sv @@
`timescale 1ns / 100ps
// time_of_day_next_match_tb: self-checking testbench for the next alarm time
// calculator, with a scoreboard that predicts every result from its own
// copy of the schedule registers. Depends on tdnm_pkg and the RTL top level.

module time_of_day_next_match_tb;
   import tdnm_pkg::*;

   localparam int DAY_HOURS     = int'(HOUR_MAX) + 1;
   localparam int MINUTE_UNITS  = int'(UNIT_MAX) + 1;
   localparam int RANDOM_PHASES = 20;
   localparam int PHASE_QUERIES = 100;
   localparam int QUIET_PHASES  = 3;
   localparam int CYCLE_LIMIT   = 400000;

   // register write masks, one bit per register index
   localparam logic [3:0] ALL_REGS  = 4'b1111;
   localparam logic [3:0] SETS_ONLY = 4'b0111;

   typedef struct packed {
      logic [WAIT_W-1:0] wait_ms;
      logic [HOUR_W-1:0] hour;
      logic [UNIT_W-1:0] minute;
      logic [UNIT_W-1:0] second;
      logic [1:0]        status;
   } alarm_t;

   // schedule copy, next alarm prediction and expected alarm store
   class alarm_scoreboard;
      logic [23:0]       hour_set;
      logic [59:0]       minute_set;
      logic [59:0]       second_set;
      logic [WAIT_W-1:0] max_wait;
      alarm_t            expected_alarms[$];
      int                errors;

      function new();
         hour_set   = '0;
         minute_set = '0;
         second_set = '0;
         max_wait   = MAX_WAIT_INIT;
         errors     = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            REG_HOUR_SET:   hour_set   = data[23:0];
            REG_MINUTE_SET: minute_set = data[59:0];
            REG_SECOND_SET: second_set = data[59:0];
            REG_MAX_WAIT:   max_wait   = data[WAIT_W-1:0];
            default: ;
         endcase
      endfunction

      // lowest allowed unit in [lo, lim), -1 when there is none
      function int first_from(logic [59:0] set_bits, int lo, int lim);
         for (int i = lo; i < lim; i++) begin
            if (set_bits[i]) return i;
         end
         return -1;
      endfunction

      function alarm_t next_alarm(logic [HOUR_W-1:0] h_in, logic [UNIT_W-1:0] m_in,
                                  logic [UNIT_W-1:0] s_in, logic [MSEC_W-1:0] ms_in);
         alarm_t r;
         int h, m, s, ms;
         int fh, fm, fs, nh, nm, ns;
         int now_sec, next_sec, wait_val;
         bit wrap;
         r = '0;
         wrap = 1'b0;
         // out-of-range times saturate
         h  = (h_in > HOUR_MAX) ? int'(HOUR_MAX) : int'(h_in);
         m  = (m_in > UNIT_MAX) ? int'(UNIT_MAX) : int'(m_in);
         s  = (s_in > UNIT_MAX) ? int'(UNIT_MAX) : int'(s_in);
         ms = (ms_in > MSEC_MAX) ? int'(MSEC_MAX) : int'(ms_in);

         fh = first_from({36'd0, hour_set}, 0, DAY_HOURS);
         fm = first_from(minute_set, 0, MINUTE_UNITS);
         fs = first_from(second_set, 0, MINUTE_UNITS);
         if (fh < 0 || fm < 0 || fs < 0) begin
            r.status = STAT_EMPTY;
            return r;
         end

         // later second this minute, then later minute this hour,
         // then later hour today, else first run time tomorrow
         nh = -1;
         nm = -1;
         ns = -1;
         if (hour_set[h] && minute_set[m]) ns = first_from(second_set, s + 1, MINUTE_UNITS);
         if (ns >= 0) begin
            nh = h;
            nm = m;
         end else begin
            if (hour_set[h]) nm = first_from(minute_set, m + 1, MINUTE_UNITS);
            if (nm >= 0) begin
               nh = h;
               ns = fs;
            end else begin
               nh = first_from({36'd0, hour_set}, h + 1, DAY_HOURS);
               if (nh >= 0) begin
                  nm = fm;
                  ns = fs;
               end else begin
                  nh = fh;
                  nm = fm;
                  ns = fs;
                  wrap = 1'b1;
               end
            end
         end

         now_sec  = h * int'(SEC_PER_HOUR) + m * int'(SEC_PER_MIN) + s;
         next_sec = nh * int'(SEC_PER_HOUR) + nm * int'(SEC_PER_MIN) + ns;
         if (wrap) next_sec += int'(SEC_PER_DAY);
         wait_val = (next_sec - now_sec) * int'(MS_PER_SEC) - ms;

         r.hour   = HOUR_W'(nh);
         r.minute = UNIT_W'(nm);
         r.second = UNIT_W'(ns);
         if (wait_val >= max_wait) begin
            r.status  = STAT_LONG;
            r.wait_ms = '0;
         end else begin
            r.status  = STAT_OK;
            r.wait_ms = WAIT_W'(wait_val);
         end
         return r;
      endfunction

      function void note_query(logic [HOUR_W-1:0] h, logic [UNIT_W-1:0] m,
                               logic [UNIT_W-1:0] s, logic [MSEC_W-1:0] ms);
         expected_alarms.push_back(next_alarm(h, m, s, ms));
      endfunction

      function int pending();
         return expected_alarms.size();
      endfunction

      function void check_alarm(alarm_t got);
         alarm_t want;
         if (expected_alarms.size() == 0) begin
            $display("%0t: alarm result with none outstanding", $time);
            errors++;
            return;
         end
         want = expected_alarms.pop_front();
         if (got.wait_ms != want.wait_ms) begin
            $display("%0t: wait_ms expected %0d, got %0d", $time, want.wait_ms, got.wait_ms);
            errors++;
         end
         if (got.hour != want.hour) begin
            $display("%0t: next_hour expected %0d, got %0d", $time, want.hour, got.hour);
            errors++;
         end
         if (got.minute != want.minute) begin
            $display("%0t: next_minute expected %0d, got %0d", $time, want.minute,
                     got.minute);
            errors++;
         end
         if (got.second != want.second) begin
            $display("%0t: next_second expected %0d, got %0d", $time, want.second,
                     got.second);
            errors++;
         end
         if (got.status != want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [HOUR_W-1:0] req_current_hour;
   logic [UNIT_W-1:0] req_current_minute;
   logic [UNIT_W-1:0] req_current_second;
   logic [MSEC_W-1:0] req_current_millisecond;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WAIT_W-1:0] rsp_wait_ms;
   logic [HOUR_W-1:0] rsp_next_hour;
   logic [UNIT_W-1:0] rsp_next_minute;
   logic [UNIT_W-1:0] rsp_next_second;
   logic [1:0]        rsp_status;
   logic              csr_write;
   logic [IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   alarm_scoreboard board;
   bit              quiet = 1'b0;
   int              cycle_count = 0;

   time_of_day_next_match DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_current_hour        (req_current_hour),
      .req_current_minute      (req_current_minute),
      .req_current_second      (req_current_second),
      .req_current_millisecond (req_current_millisecond),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_wait_ms             (rsp_wait_ms),
      .rsp_next_hour           (rsp_next_hour),
      .rsp_next_minute         (rsp_next_minute),
      .rsp_next_second         (rsp_next_second),
      .rsp_status              (rsp_status),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side backpressure in random bursts, none once quiet
   initial begin
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!quiet) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // note accepted queries and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_query(req_current_hour, req_current_minute, req_current_second,
                             req_current_millisecond);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_alarm({rsp_wait_ms, rsp_next_hour, rsp_next_minute,
                               rsp_next_second, rsp_status});
         end
      end
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("time_of_day_next_match_tb: FAIL");
         $finish;
      end
   end

   // one query transaction, held until accepted
   task automatic send_query(input logic [HOUR_W-1:0] h, input logic [UNIT_W-1:0] m,
                             input logic [UNIT_W-1:0] s, input logic [MSEC_W-1:0] ms);
      req_valid               <= 1'b1;
      req_current_hour        <= h;
      req_current_minute      <= m;
      req_current_second      <= s;
      req_current_millisecond <= ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // stop sending until every outstanding alarm has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.set_reg(idx, data);
   endtask

   task automatic load_regs(input logic [CSR_W-1:0] hs, input logic [CSR_W-1:0] mns,
                            input logic [CSR_W-1:0] scs, input logic [CSR_W-1:0] mw,
                            input logic [3:0] which);
      if (which[REG_HOUR_SET])   write_reg(REG_HOUR_SET, hs);
      if (which[REG_MINUTE_SET]) write_reg(REG_MINUTE_SET, mns);
      if (which[REG_SECOND_SET]) write_reg(REG_SECOND_SET, scs);
      if (which[REG_MAX_WAIT])   write_reg(REG_MAX_WAIT, mw);
      csr_write <= 1'b0;
   endtask

   // random schedule: full, single, sparse, dense, one missing, or empty
   function automatic logic [59:0] random_set(int lim);
      logic [59:0] v;
      v = '0;
      case ($urandom_range(0, 19))
         0, 1:    v = '1;
         2, 3, 4: v[$urandom_range(0, lim - 1)] = 1'b1;
         5, 6, 7: repeat ($urandom_range(2, 4)) v[$urandom_range(0, lim - 1)] = 1'b1;
         8:       begin
            v = '1;
            v[$urandom_range(0, lim - 1)] = 1'b0;
         end
         19:      v = '0;
         default: v = 60'({$urandom, $urandom});
      endcase
      return v & ((60'd1 << lim) - 60'd1);
   endfunction

   // mostly an allowed unit, sometimes any unit in range
   function automatic int pick_unit(logic [59:0] set_bits, int lim);
      int n;
      int k;
      n = 0;
      for (int i = 0; i < lim; i++) n += set_bits[i];
      if (n == 0 || $urandom_range(0, 3) == 0) return $urandom_range(0, lim - 1);
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < lim; i++) begin
         if (set_bits[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return 0;
   endfunction

   initial begin : stimulus
      logic [59:0] hs, mns, scs, mw;
      logic [3:0]  which;
      int          sel;
      board = new();
      reset                   <= 1'b1;
      req_valid               <= 1'b0;
      req_current_hour        <= '0;
      req_current_minute      <= '0;
      req_current_second      <= '0;
      req_current_millisecond <= '0;
      csr_write               <= 1'b0;
      csr_index               <= REG_HOUR_SET;
      csr_wdata               <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sets still empty after reset
      send_query(0, 0, 0, 0);
      send_query(31, 63, 63, 1023);
      drain();

      // one run time a day, maximum wait left at its reset value
      load_regs(60'd1 << 5, 60'd1 << 30, 60'd1 << 15, '0, SETS_ONLY);
      send_query(5, 30, 15, 0);
      send_query(5, 30, 15, 999);
      send_query(0, 0, 0, 0);
      send_query(23, 59, 59, 999);
      drain();

      // every second allowed, including day wrap and saturated inputs
      load_regs('1, '1, '1, CSR_W'(MAX_WAIT_INIT), ALL_REGS);
      send_query(0, 0, 0, 0);
      send_query(23, 59, 59, 999);
      send_query(31, 63, 63, 1023);
      send_query(12, 34, 56, 500);
      send_query(23, 58, 59, 0);
      drain();

      // zero maximum, then a maximum of one millisecond
      load_regs('1, '1, '1, '0, ALL_REGS);
      send_query(10, 10, 10, 10);
      send_query(0, 0, 0, 0);
      drain();
      load_regs('1, '1, '1, 60'd1, ALL_REGS);
      send_query(0, 0, 0, 999);
      drain();

      // hour zero only, edge seconds, junk above register widths
      load_regs(60'hFFFFFFFFF000001, '1, 60'h800000000000001, 60'hAAAAAAAAFFFFFFF,
                ALL_REGS);
      send_query(0, 59, 59, 0);
      send_query(0, 10, 0, 5);
      send_query(5, 0, 0, 0);
      send_query(0, 59, 0, 0);
      drain();

      // minute set empty
      load_regs('1, '0, '1, CSR_W'(MAX_WAIT_INIT), ALL_REGS);
      send_query(7, 7, 7, 7);
      drain();

      // random schedules with queries clustered on allowed times
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         quiet = (p >= RANDOM_PHASES - QUIET_PHASES);
         hs  = random_set(DAY_HOURS);
         if ($urandom_range(0, 3) == 0) hs = hs | (60'({$urandom, $urandom}) << DAY_HOURS);
         mns = random_set(MINUTE_UNITS);
         scs = random_set(MINUTE_UNITS);
         case ($urandom_range(0, 11))
            0:       mw = '0;
            1:       mw = {33'($urandom), 27'h7FFFFFF};
            2:       mw = 60'($urandom_range(1, 5000));
            3:       mw = 60'($urandom_range(1, 3600000));
            4, 5:    mw = 60'($urandom_range(1, 86400000));
            default: mw = 60'(MAX_WAIT_INIT);
         endcase
         which = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : ALL_REGS;
         load_regs(hs, mns, scs, mw, which);

         repeat (PHASE_QUERIES) begin
            idle_gap();
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
               send_query(HOUR_W'($urandom), UNIT_W'($urandom), UNIT_W'($urandom),
                          MSEC_W'($urandom));
            end else if (sel < 7) begin
               send_query(HOUR_W'(pick_unit({36'd0, board.hour_set}, DAY_HOURS)),
                          UNIT_W'(pick_unit(board.minute_set, MINUTE_UNITS)),
                          UNIT_W'(pick_unit(board.second_set, MINUTE_UNITS)),
                          MSEC_W'($urandom_range(0, 999)));
            end else begin
               send_query(HOUR_W'($urandom_range(0, 23)), UNIT_W'($urandom_range(0, 59)),
                          UNIT_W'($urandom_range(0, 59)), MSEC_W'($urandom_range(0, 999)));
            end
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("time_of_day_next_match_tb: PASS");
      end else begin
         $display("time_of_day_next_match_tb: FAIL");
      end
      $finish;
   end

endmodule
